@@ sv/idle_and_low_battery_power_supervisor_assert.svh @@
// Assertion macros shared by the supervisor RTL
`ifndef IDLE_AND_LOW_BATTERY_POWER_SUPERVISOR_ASSERT_SVH
`define IDLE_AND_LOW_BATTERY_POWER_SUPERVISOR_ASSERT_SVH

// Check a property on every rising edge, masked while reset is held
`define IPBS_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define IPBS_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/ipbs_pkg.sv @@
`timescale 1ns / 1ps
package ipbs_pkg;

	// Pending request codes
	localparam logic [1:0] REQ_NONE     = 2'd0;
	localparam logic [1:0] REQ_SUSPEND  = 2'd1;
	localparam logic [1:0] REQ_SHUTDOWN = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SUSPEND_PERIOD  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRACE_PERIOD    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_PERCENT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_ENABLE  = 3'd4;

	// Configuration reset values
	localparam logic [31:0] RST_SHUTDOWN_PERIOD = 32'd900000;
	localparam logic [31:0] RST_SUSPEND_PERIOD  = 32'd300000;
	localparam logic [31:0] RST_GRACE_PERIOD    = 32'd60000;
	localparam logic [6:0]  RST_LOW_PERCENT     = 7'd5;
	localparam logic        RST_MONITOR_ENABLE  = 1'b1;

	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 8;

	typedef struct packed {
		logic [31:0] shutdown_period_ms;
		logic [31:0] suspend_period_ms;
		logic [31:0] grace_period_ms;
		logic [6:0]  low_battery_percent;
		logic        battery_monitor_enable;
	} cfg_t;

	// Input word, last field in the lowest bits
	typedef struct packed {
		logic        shutdown_ask;
		logic        request_ack;
		logic        activity;
		logic [6:0]  battery_percent;
		logic [15:0] battery_reading;
		logic        external_power;
		logic [31:0] now_ms;
	} item_t;

	// Result word, last field in the lowest bits
	typedef struct packed {
		logic       low_battery;
		logic [1:0] pending_request;
		logic       shutdown;
	} result_t;

	localparam int ITEM_W   = $bits(item_t);
	localparam int RESULT_W = $bits(result_t);

endpackage

@@ sv/idle_and_low_battery_power_supervisor.sv @@
`timescale 1ns / 1ps
`include "idle_and_low_battery_power_supervisor_assert.svh"
// Idle and low-battery power supervisor. Each input word is one periodic tick; each tick
// yields exactly one result word via the input stage register and the result register,
// and a new tick is taken every cycle while the result side keeps up. The rate is set by
// the combinational subtract-and-compare update of the supervisor state between those two
// registers. Configuration writes are taken at any time on the cfg channel (cfg_ready is
// always high) and must only be issued while the block is idle.
module idle_and_low_battery_power_supervisor (
	input  logic                              clk,
	input  logic                              arst_n,
	// now_ms[31:0], external_power[32], battery_reading[48:33], battery_percent[55:49],
	// activity[56], request_ack[57], shutdown_ask[58], zero pad[63:59]
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [ipbs_pkg::IN_DATA_W-1:0]    s_tdata,
	// shutdown[0], pending_request[2:1], low_battery[3], zero pad[7:4]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ipbs_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ipbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ipbs_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import ipbs_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    vld_s1;
	result_t res;
	result_t res_q;
	logic    out_vld_q;
	logic    advance;

	ipbs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage 1 moves on whenever the result register is free or being drained
	assign advance  = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || advance;

	// Input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_t'(s_tdata[ITEM_W-1:0]);
		end
	end

	ipbs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(OUT_DATA_W-RESULT_W){1'b0}}, res_q};

	`IPBS_ASSERT(a_ready_when_empty, clk, arst_n, !out_vld_q |-> s_tready, "input stalled with empty result register")
	`IPBS_ASSERT(a_result_has_source, clk, arst_n, $rose(out_vld_q) |-> $past(vld_s1), "result word without a ticked item")
	`IPBS_ASSERT(a_shutdown_sticks, clk, arst_n, (advance && res_q.shutdown && out_vld_q) |=> res_q.shutdown, "shutdown result dropped")

endmodule

@@ sv/ipbs_cfg.sv @@
`timescale 1ns / 1ps
module ipbs_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ipbs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ipbs_pkg::CFG_DATA_W-1:0]    cfg_data,
	output ipbs_pkg::cfg_t                     cfg
);
	import ipbs_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Decode the index and latch the addressed register; unknown indexes drop the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shutdown_period_ms     <= RST_SHUTDOWN_PERIOD;
			cfg_q.suspend_period_ms      <= RST_SUSPEND_PERIOD;
			cfg_q.grace_period_ms        <= RST_GRACE_PERIOD;
			cfg_q.low_battery_percent    <= RST_LOW_PERCENT;
			cfg_q.battery_monitor_enable <= RST_MONITOR_ENABLE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SHUTDOWN_PERIOD: cfg_q.shutdown_period_ms     <= cfg_data;
				CFG_SUSPEND_PERIOD:  cfg_q.suspend_period_ms      <= cfg_data;
				CFG_GRACE_PERIOD:    cfg_q.grace_period_ms        <= cfg_data;
				CFG_LOW_PERCENT:     cfg_q.low_battery_percent    <= cfg_data[6:0];
				CFG_MONITOR_ENABLE:  cfg_q.battery_monitor_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

@@ sv/ipbs_core.sv @@
`timescale 1ns / 1ps
`include "idle_and_low_battery_power_supervisor_assert.svh"
module ipbs_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  ipbs_pkg::item_t   item,
	input  ipbs_pkg::cfg_t    cfg,
	output ipbs_pkg::result_t res
);
	import ipbs_pkg::*;

	logic        keep_awake_q;
	logic [31:0] idle_mark_q;
	logic [1:0]  request_q;
	logic        low_bat_q;
	logic [31:0] grace_mark_q;
	logic        halted_q;

	logic        keep_awake_d;
	logic [31:0] idle_mark_d;
	logic [1:0]  request_d;
	logic        low_bat_d;
	logic [31:0] grace_mark_d;
	logic        halted_d;

	logic [31:0] mark_eff;
	logic [31:0] idle_elapsed;
	logic [31:0] grace_elapsed;
	logic        low_detect;
	logic        scan;

	// Elapsed times wrap modulo 2^32; an unset idle mark is taken up from now
	assign mark_eff      = (idle_mark_q == 32'd0) ? item.now_ms : idle_mark_q;
	assign idle_elapsed  = item.now_ms - mark_eff;
	assign grace_elapsed = item.now_ms - grace_mark_q;
	assign low_detect    = !item.external_power && (item.battery_reading != 16'd0) &&
		(item.battery_percent < cfg.low_battery_percent);

	// Next state for one tick
	always_comb begin
		keep_awake_d = keep_awake_q;
		idle_mark_d  = idle_mark_q;
		request_d    = request_q;
		low_bat_d    = low_bat_q;
		grace_mark_d = grace_mark_q;
		halted_d     = halted_q;
		scan         = 1'b0;
		if (!halted_q) begin
			if (item.request_ack) begin
				request_d = REQ_NONE;
			end
			if (item.shutdown_ask) begin
				request_d = REQ_SHUTDOWN;
			end
			if (item.activity) begin
				keep_awake_d = 1'b1;
			end
			// Battery watch decides whether the idle scan runs
			if (cfg.battery_monitor_enable) begin
				if (!low_bat_q) begin
					if (low_detect) begin
						low_bat_d    = 1'b1;
						grace_mark_d = item.now_ms;
					end else begin
						scan = 1'b1;
					end
				end else if (item.external_power) begin
					low_bat_d = 1'b0;
				end else if (grace_elapsed > cfg.grace_period_ms) begin
					halted_d = 1'b1;
				end
			end else if (!low_bat_q) begin
				scan = 1'b1;
			end else begin
				low_bat_d = 1'b0;
			end
			// Idle scan: consume the keep-awake mark, else check the periods
			if (scan) begin
				if (keep_awake_d) begin
					request_d    = REQ_NONE;
					keep_awake_d = 1'b0;
					idle_mark_d  = item.now_ms;
				end else begin
					idle_mark_d = mark_eff;
					if (!item.external_power && idle_elapsed > cfg.shutdown_period_ms) begin
						halted_d = 1'b1;
					end else if (idle_elapsed > cfg.suspend_period_ms) begin
						request_d = REQ_SUSPEND;
					end
				end
			end
		end
	end

	// Commit the tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_awake_q <= 1'b0;
			idle_mark_q  <= 32'd0;
			request_q    <= REQ_NONE;
			low_bat_q    <= 1'b0;
			grace_mark_q <= 32'd0;
			halted_q     <= 1'b0;
		end else if (step) begin
			keep_awake_q <= keep_awake_d;
			idle_mark_q  <= idle_mark_d;
			request_q    <= request_d;
			low_bat_q    <= low_bat_d;
			grace_mark_q <= grace_mark_d;
			halted_q     <= halted_d;
		end
	end

	assign res.shutdown        = halted_d;
	assign res.pending_request = request_d;
	assign res.low_battery     = low_bat_d;

	`IPBS_ASSERT(a_halt_latched, clk, arst_n, halted_q |=> halted_q, "shutdown released without reset")
	`IPBS_ASSERT(a_halt_freezes, clk, arst_n, (halted_q && step) |=> ($stable(request_q) && $stable(low_bat_q)), "state moved after shutdown")
	`IPBS_ASSERT_ALWAYS(a_req_code, clk, !arst_n || (request_q != 2'd3), "undefined request code")

endmodule
